// ===== rtl/per_pkg.sv =====
`timescale 1ns / 1ps
// per_pkg: shared constants and register codes for the point rotation block
package per_pkg;

	localparam int ROW_BITS       = 12;
	localparam int TRIG_BITS      = 16;
	localparam int COORD_BITS_DEF = 32;
	localparam int TRIG_FRAC_DEF  = 14;
	localparam int ENA_BITS       = 3;
	localparam int CFG_IDX_BITS   = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLES   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_COS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_SIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BETA_COS  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BETA_SIN  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAMMA_COS = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAMMA_SIN = 3'd6;

	// bit positions in the enable register
	localparam int ENA_ALPHA = 0;
	localparam int ENA_BETA  = 1;
	localparam int ENA_GAMMA = 2;

	// axis a rotation cell turns about
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	// 1.0 in signed Q2.14
	localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = 16'sd16384;

	// three cells, three register stages each
	localparam int NUM_CELLS   = 3;
	localparam int CELL_STAGES = 3;
	localparam int PIPE_DEPTH  = NUM_CELLS * CELL_STAGES;

endpackage

// ===== rtl/per_point_if.sv =====
`timescale 1ns / 1ps
// per_point_if: point channel, used at the block input and between cells
interface per_point_if #(
	parameter int COORD_BITS = per_pkg::COORD_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [per_pkg::ROW_BITS-1:0]  grid_row;
	logic [per_pkg::ROW_BITS-1:0]  grid_col;
	logic signed [COORD_BITS-1:0]  point_x;
	logic signed [COORD_BITS-1:0]  point_y;
	logic signed [COORD_BITS-1:0]  point_z;

	modport source (output valid, grid_row, grid_col, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, grid_row, grid_col, point_x, point_y, point_z,
		output ready);
endinterface

// ===== rtl/per_result_if.sv =====
`timescale 1ns / 1ps
// per_result_if: rotated point channel at the block output
interface per_result_if #(
	parameter int COORD_BITS = per_pkg::COORD_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [per_pkg::ROW_BITS-1:0]  out_row;
	logic [per_pkg::ROW_BITS-1:0]  out_col;
	logic signed [COORD_BITS-1:0]  rotated_x;
	logic signed [COORD_BITS-1:0]  rotated_y;
	logic signed [COORD_BITS-1:0]  rotated_z;

	modport source (output valid, out_row, out_col, rotated_x, rotated_y, rotated_z,
		input ready);
	modport sink (input valid, out_row, out_col, rotated_x, rotated_y, rotated_z,
		output ready);
endinterface

// ===== rtl/per_cfg_if.sv =====
`timescale 1ns / 1ps
// per_cfg_if: register write channel
interface per_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [per_pkg::CFG_IDX_BITS-1:0]    index;
	logic [per_pkg::TRIG_BITS-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/point_euler_rotation.sv =====
`timescale 1ns / 1ps
// point_euler_rotation: top level, registers and the chain of rotation cells
//
// Rotates each map point about the origin: first about z (gamma),
// then y (beta), then x (alpha), each step only when its enable bit is set.
// Coordinates are signed Q16.16, the cosine and sine registers signed Q2.14.
// Every product is rounded with halves toward plus infinity and each step
// saturates its two outputs. Row and column ride along untouched.
// Throughput is one point per cycle while results are taken. An accepted
// point reaches its result word through three cells (gamma, beta, alpha),
// each with a multiply stage, a rounding stage and a sum/saturate stage.
// The last cell's third stage is the output register, so a stalled result
// does not stop the cells upstream from filling. Register writes are always
// ready; they must only happen while no point is in flight.
module point_euler_rotation #(
	parameter int COORD_BITS     = per_pkg::COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = per_pkg::TRIG_FRAC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	per_point_if.sink     point,
	per_result_if.source  result,
	per_cfg_if.sink       cfg
);
	localparam int TB = per_pkg::TRIG_BITS;

	// configuration registers
	logic [per_pkg::ENA_BITS-1:0] enables_q;
	logic signed [TB-1:0] alpha_cos_q, alpha_sin_q;
	logic signed [TB-1:0] beta_cos_q, beta_sin_q;
	logic signed [TB-1:0] gamma_cos_q, gamma_sin_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q   <= '0;
			alpha_cos_q <= per_pkg::TRIG_ONE;
			alpha_sin_q <= '0;
			beta_cos_q  <= per_pkg::TRIG_ONE;
			beta_sin_q  <= '0;
			gamma_cos_q <= per_pkg::TRIG_ONE;
			gamma_sin_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				per_pkg::REG_ENABLES:   enables_q   <= cfg.data[per_pkg::ENA_BITS-1:0];
				per_pkg::REG_ALPHA_COS: alpha_cos_q <= cfg.data;
				per_pkg::REG_ALPHA_SIN: alpha_sin_q <= cfg.data;
				per_pkg::REG_BETA_COS:  beta_cos_q  <= cfg.data;
				per_pkg::REG_BETA_SIN:  beta_sin_q  <= cfg.data;
				per_pkg::REG_GAMMA_COS: gamma_cos_q <= cfg.data;
				per_pkg::REG_GAMMA_SIN: gamma_sin_q <= cfg.data;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// links between the cells
	per_point_if #(.COORD_BITS(COORD_BITS)) gamma_to_beta ();
	per_point_if #(.COORD_BITS(COORD_BITS)) beta_to_alpha ();
	per_point_if #(.COORD_BITS(COORD_BITS)) alpha_out ();

	// gamma: turns (x, y) about z
	per_rot_cell #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.AXIS           (per_pkg::AXIS_Z)
	) u_gamma (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (enables_q[per_pkg::ENA_GAMMA]),
		.cosv   (gamma_cos_q),
		.sinv   (gamma_sin_q),
		.up     (point),
		.dn     (gamma_to_beta)
	);

	// beta: turns (x, z) about y
	per_rot_cell #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.AXIS           (per_pkg::AXIS_Y)
	) u_beta (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (enables_q[per_pkg::ENA_BETA]),
		.cosv   (beta_cos_q),
		.sinv   (beta_sin_q),
		.up     (gamma_to_beta),
		.dn     (beta_to_alpha)
	);

	// alpha: turns (y, z) about x; its last stage is the output register
	per_rot_cell #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.AXIS           (per_pkg::AXIS_X)
	) u_alpha (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (enables_q[per_pkg::ENA_ALPHA]),
		.cosv   (alpha_cos_q),
		.sinv   (alpha_sin_q),
		.up     (beta_to_alpha),
		.dn     (alpha_out)
	);

	// result word
	assign result.valid     = alpha_out.valid;
	assign alpha_out.ready  = result.ready;
	assign result.out_row   = alpha_out.grid_row;
	assign result.out_col   = alpha_out.grid_col;
	assign result.rotated_x = alpha_out.point_x;
	assign result.rotated_y = alpha_out.point_y;
	assign result.rotated_z = alpha_out.point_z;

endmodule

// ===== rtl/per_rot_cell.sv =====
`timescale 1ns / 1ps
// per_rot_cell: one axis rotation, multiply / round / sum-and-saturate stages
module per_rot_cell #(
	parameter int COORD_BITS     = per_pkg::COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = per_pkg::TRIG_FRAC_DEF,
	parameter int AXIS           = per_pkg::AXIS_Z
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic signed [per_pkg::TRIG_BITS-1:0]  cosv,
	input  logic signed [per_pkg::TRIG_BITS-1:0]  sinv,
	per_point_if.sink                             up,
	per_point_if.source                           dn
);
	localparam int TB = per_pkg::TRIG_BITS;
	localparam int RB = per_pkg::ROW_BITS;
	localparam int NB = TB + 1;            // room for negated sine
	localparam int PW = COORD_BITS + NB;   // product width
	localparam int SW = PW + 1;            // sum width

	localparam logic signed [PW-1:0] RND  = PW'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SMAX = (SW'(1) << (COORD_BITS - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	logic go1, go2, go3;
	logic v1_q, v2_q, v3_q;

	// pair (a, b) to rotate, k passes by
	logic signed [COORD_BITS-1:0] in_a, in_b, in_k;
	logic signed [NB-1:0] c_w, s_w, ns_w;

	logic signed [COORD_BITS-1:0] a_s1, b_s1, k_s1, a_s2, b_s2, k_s2, a_s3, b_s3, k_s3;
	logic [RB-1:0] row_s1, col_s1, row_s2, col_s2, row_s3, col_s3;
	logic signed [PW-1:0] pac_s1, pbs_s1, pans_s1, pbc_s1;
	logic signed [PW-1:0] rac_s2, rbs_s2, rans_s2, rbc_s2;
	logic signed [PW-1:0] t_ac, t_bs, t_ans, t_bc;
	logic signed [SW-1:0] sum_a, sum_b;
	logic signed [COORD_BITS-1:0] sat_a, sat_b;

	always_comb begin
		case (AXIS)
			per_pkg::AXIS_Z: begin
				in_a = up.point_x; in_b = up.point_y; in_k = up.point_z;
			end
			per_pkg::AXIS_Y: begin
				in_a = up.point_x; in_b = up.point_z; in_k = up.point_y;
			end
			default: begin
				in_a = up.point_y; in_b = up.point_z; in_k = up.point_x;
			end
		endcase
	end

	assign c_w  = NB'(cosv);
	assign s_w  = NB'(sinv);
	assign ns_w = -s_w;

	assign go3 = !v3_q || dn.ready;
	assign go2 = !v2_q || go3;
	assign go1 = !v1_q || go2;
	assign up.ready = go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (go1) v1_q <= up.valid;
			if (go2) v2_q <= v1_q;
			if (go3) v3_q <= v2_q;
		end
	end

	// stage 1: the four products
	always_ff @(posedge clk) begin
		if (go1 && up.valid) begin
			a_s1    <= in_a;
			b_s1    <= in_b;
			k_s1    <= in_k;
			row_s1  <= up.grid_row;
			col_s1  <= up.grid_col;
			pac_s1  <= PW'(in_a * c_w);
			pbs_s1  <= PW'(in_b * s_w);
			pans_s1 <= PW'(in_a * ns_w);
			pbc_s1  <= PW'(in_b * c_w);
		end
	end

	// stage 2: round each product, halves go up
	always_comb begin
		t_ac  = pac_s1 + RND;
		t_bs  = pbs_s1 + RND;
		t_ans = pans_s1 + RND;
		t_bc  = pbc_s1 + RND;
	end

	always_ff @(posedge clk) begin
		if (go2 && v1_q) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			k_s2    <= k_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			rac_s2  <= t_ac >>> TRIG_FRAC_BITS;
			rbs_s2  <= t_bs >>> TRIG_FRAC_BITS;
			rans_s2 <= t_ans >>> TRIG_FRAC_BITS;
			rbc_s2  <= t_bc >>> TRIG_FRAC_BITS;
		end
	end

	// stage 3: sum and clamp to the coordinate range
	always_comb begin
		sum_a = SW'(rac_s2) + SW'(rbs_s2);
		sum_b = SW'(rans_s2) + SW'(rbc_s2);
		if (sum_a > SMAX)      sat_a = SMAX[COORD_BITS-1:0];
		else if (sum_a < SMIN) sat_a = SMIN[COORD_BITS-1:0];
		else                   sat_a = sum_a[COORD_BITS-1:0];
		if (sum_b > SMAX)      sat_b = SMAX[COORD_BITS-1:0];
		else if (sum_b < SMIN) sat_b = SMIN[COORD_BITS-1:0];
		else                   sat_b = sum_b[COORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (go3 && v2_q) begin
			a_s3   <= en ? sat_a : a_s2;
			b_s3   <= en ? sat_b : b_s2;
			k_s3   <= k_s2;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
		end
	end

	assign dn.valid    = v3_q;
	assign dn.grid_row = row_s3;
	assign dn.grid_col = col_s3;

	always_comb begin
		case (AXIS)
			per_pkg::AXIS_Z: begin
				dn.point_x = a_s3; dn.point_y = b_s3; dn.point_z = k_s3;
			end
			per_pkg::AXIS_Y: begin
				dn.point_x = a_s3; dn.point_z = b_s3; dn.point_y = k_s3;
			end
			default: begin
				dn.point_y = a_s3; dn.point_z = b_s3; dn.point_x = k_s3;
			end
		endcase
	end

endmodule

// ===== rtl/per_chk.sv =====
`timescale 1ns / 1ps
// per_chk: port-level checks on the point rotation block, bound to the top
module per_chk #(
	parameter int COORD_BITS = per_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [per_pkg::ROW_BITS-1:0] out_row,
	input logic [per_pkg::ROW_BITS-1:0] out_col,
	input logic [COORD_BITS-1:0]        rotated_x,
	input logic [COORD_BITS-1:0]        rotated_y,
	input logic [COORD_BITS-1:0]        rotated_z
);
	localparam int DEPTH = per_pkg::PIPE_DEPTH;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic                in_acc, out_acc;
	logic [CNT_BITS-1:0] inflight_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_BITS'(in_acc) - CNT_BITS'(out_acc);
		end
	end

	// no result word without a point inside
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result word with no point in flight");

	// never more points inside than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_BITS'(DEPTH))
		else $error("more points in flight than stages");

	// an empty block always takes a point
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> in_ready)
		else $error("empty block not ready");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
			&& $stable(rotated_x) && $stable(rotated_y) && $stable(rotated_z))
		else $error("stalled result word changed");

endmodule

bind point_euler_rotation per_chk #(.COORD_BITS(COORD_BITS)) u_per_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_row   (result.out_row),
	.out_col   (result.out_col),
	.rotated_x (result.rotated_x),
	.rotated_y (result.rotated_y),
	.rotated_z (result.rotated_z)
);
